>>> rtl/core/arctangent_polynomial_top_defines.svh
// Assertion macros used by the checker file of the arc tangent block.
`ifndef ARCTANGENT_POLYNOMIAL_TOP_DEFINES_SVH
`define ARCTANGENT_POLYNOMIAL_TOP_DEFINES_SVH
// Antecedent implies consequent in the next cycle.
`define AP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// Antecedent implies consequent in the same cycle.
`define AP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

>>> rtl/core/atanp_pkg.sv
// Package: widths, Q1.30 coefficients and fixed-point constants of the arc tangent pipeline.
`default_nettype none
package atanp_pkg;
	localparam int SampleW = 32;
	localparam int AngleW  = 31;
	localparam int FracW   = 30;
	localparam int NumCoef = 8;
	localparam int QuotW   = 31;	// quotient of 2*|t|, below 2^31; its lsb rounds
	localparam int DivSteps = QuotW; // one quotient bit per step
	localparam logic signed [31:0] Pi4Q30 = 32'sd843314857;
	localparam logic signed [31:0] HalfPiQ29 = 32'sd843314857;
	localparam logic [32:0] OneQ16 = 33'd65536;

	typedef logic signed [31:0] q30_t;

	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic               is_last;
	} sample_beat_t;

	typedef struct packed {
		logic signed [AngleW-1:0] angle;
		logic                     end_of_vector;
	} angle_beat_t;

	function automatic q30_t coef(input int k);
		case (k)
			0: coef = 32'sd1073741108;
			1: coef = -32'sd357876604;
			2: coef = 32'sd214174299;
			3: coef = -32'sd149341741;
			4: coef = 32'sd103530234;
			5: coef = -32'sd60032783;
			6: coef = 32'sd23473316;
			default: coef = -32'sd4353012;
		endcase
	endfunction

	// Product of two Q1.30 values, rounded to nearest with ties away from zero.
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		logic [63:0] m;
		logic [63:0] r;
		p = 64'(a) * 64'(b);
		m = p[63] ? 64'(-p) : 64'(p);
		r = (m + 64'(1) * (64'd1 << (FracW - 1))) >> FracW;
		mul_q30 = p[63] ? -q30_t'(r[31:0]) : q30_t'(r[31:0]);
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/atanp_stream_if.sv
// Interface: valid/ready stream channel with a generic payload type.
`default_nettype none
interface atanp_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/arctangent_polynomial_top.sv
// Top level: pipelined arc tangent, divider then Horner polynomial.
//
//  channel | dir | payload                 | handshake
//  in_s    | in  | sample[31:0], is_last   | valid/ready
//  out_m   | out | angle[30:0], end_of_vector | valid/ready
//
// One beat enters per cycle while the output is not stalled. The stages are
// 1 magnitude, 31 divider steps, 1 square, 7 Horner steps, 1 product with t,
// and 1 finish and output register. The restoring divider sets the depth: one
// quotient bit per stage. Reset clears only valid bits. A stall at the output
// freezes the whole pipe; nothing is dropped or repeated.
`default_nettype none
module arctangent_polynomial_top
	import atanp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	atanp_stream_if.sink   in_s,
	atanp_stream_if.source out_m
);
	localparam int NDiv = DivSteps;
	localparam int NPoly = NumCoef;

	// Pipeline advances when the output register is free or being drained.
	logic adv;
	assign adv = !out_m.valid || out_m.ready;
	assign in_s.ready = adv;

	// Stage 1: magnitude, numerator and divisor.
	logic        v_s1, neg_s1, last_s1, ge_s1;
	logic [32:0] num_s1, den_s1;
	logic [31:0] raw;
	logic [31:0] mag;
	assign raw = in_s.data.sample;
	assign mag = !raw[31] ? raw : (raw == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'(-raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_s.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1  <= raw[31];
			last_s1 <= in_s.data.is_last;
			ge_s1   <= {1'b0, mag} >= OneQ16;
			num_s1  <= ({1'b0, mag} >= OneQ16) ? {1'b0, mag} - OneQ16 : OneQ16 - {1'b0, mag};
			den_s1  <= {1'b0, mag} + OneQ16;
		end
	end

	// Divider stages: restoring, one quotient bit per stage, computing
	// floor(2*num*2^30/den) so the last bit rounds the quotient.
	logic        dv   [NDiv+1];
	logic        dneg [NDiv+1];
	logic        dlast[NDiv+1];
	logic        dge  [NDiv+1];
	logic [32:0] dden [NDiv+1];
	logic [33:0] drem [NDiv+1];
	logic [NDiv-1:0] dquo [NDiv+1];

	assign dv[0] = v_s1;
	assign dneg[0] = neg_s1;
	assign dlast[0] = last_s1;
	assign dge[0] = ge_s1;
	assign dden[0] = den_s1;
	assign drem[0] = {1'b0, num_s1};
	assign dquo[0] = '0;

	// num <= den, so the quotient fits in NDiv bits; the long division starts
	// with remainder num and shifts in zeros. When num equals den every bit
	// comes out set, which still rounds to exactly one.
	genvar g;
	generate
		for (g = 0; g < NDiv; g++) begin : g_div
			logic [33:0] rin, trial;
			logic        bitq;
			assign rin = drem[g];
			assign trial = {rin[32:0], 1'b0};
			assign bitq = trial >= {1'b0, dden[g]};
			logic v_sx;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sx <= 1'b0;
				end else if (adv) begin
					v_sx <= dv[g];
				end
			end
			logic neg_sx, last_sx, ge_sx;
			logic [32:0] den_sx;
			logic [33:0] rem_sx;
			logic [NDiv-1:0] quo_sx;
			always_ff @(posedge clk) begin
				if (adv) begin
					neg_sx  <= dneg[g];
					last_sx <= dlast[g];
					ge_sx   <= dge[g];
					den_sx  <= dden[g];
					rem_sx  <= bitq ? trial - {1'b0, dden[g]} : trial;
					quo_sx  <= {dquo[g][NDiv-2:0], bitq};
				end
			end
			assign dv[g+1] = v_sx;
			assign dneg[g+1] = neg_sx;
			assign dlast[g+1] = last_sx;
			assign dge[g+1] = ge_sx;
			assign dden[g+1] = den_sx;
			assign drem[g+1] = rem_sx;
			assign dquo[g+1] = quo_sx;
		end
	endgenerate

	// Quotient of num*2^31/den; add one and halve for round-half-up.
	logic [NDiv-1:0] qfull;
	logic [NDiv:0]   qrnd;
	q30_t tval;
	assign qfull = dquo[NDiv];
	assign qrnd = ({1'b0, qfull} + (NDiv+1)'(1)) >> 1;
	assign tval = dge[NDiv] ? q30_t'(qrnd) : -q30_t'(qrnd);

	// Square stage: t and u = t*t.
	logic v_sq, neg_sq, last_sq;
	q30_t t_sq, u_sq;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq <= 1'b0;
		end else if (adv) begin
			v_sq <= dv[NDiv];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_sq  <= dneg[NDiv];
			last_sq <= dlast[NDiv];
			t_sq    <= tval;
			u_sq    <= mul_q30(tval, tval);
		end
	end

	// Horner stages: p = p*u + c_k, one product per stage, then p*t.
	logic hv   [NPoly];
	logic hneg [NPoly];
	logic hlast[NPoly];
	q30_t ht   [NPoly];
	q30_t hu   [NPoly];
	q30_t hp   [NPoly];
	assign hv[0] = v_sq;
	assign hneg[0] = neg_sq;
	assign hlast[0] = last_sq;
	assign ht[0] = t_sq;
	assign hu[0] = u_sq;
	assign hp[0] = coef(NPoly - 1);

	generate
		for (g = 0; g < NPoly; g++) begin : g_horn
			q30_t pnext;
			logic v_sx;
			logic neg_sx, last_sx;
			q30_t t_sx, u_sx, p_sx;
			if (g < NPoly - 1) begin : g_step
				assign pnext = mul_q30(hp[g], hu[g]) + coef(NPoly - 2 - g);
			end else begin : g_last
				assign pnext = mul_q30(hp[g], ht[g]);
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sx <= 1'b0;
				end else if (adv) begin
					v_sx <= hv[g];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					neg_sx  <= hneg[g];
					last_sx <= hlast[g];
					t_sx    <= ht[g];
					u_sx    <= hu[g];
					p_sx    <= pnext;
				end
			end
			if (g < NPoly - 1) begin : g_fwd
				assign hv[g+1] = v_sx;
				assign hneg[g+1] = neg_sx;
				assign hlast[g+1] = last_sx;
				assign ht[g+1] = t_sx;
				assign hu[g+1] = u_sx;
				assign hp[g+1] = p_sx;
			end else begin : g_end
				// Finish: add pi/4, clamp, round to Q2.29, apply sign.
				logic signed [32:0] z;
				logic [31:0] zc;
				logic [AngleW-1:0] zr;
				always_comb begin
					z = 33'(p_sx) + 33'(Pi4Q30);
					zc = z[32] ? 32'd0 : z[31:0];
					zr = AngleW'((33'(zc) + 33'd1) >> 1);
					if (zr > AngleW'(HalfPiQ29)) begin
						zr = AngleW'(HalfPiQ29);
					end
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						out_m.valid <= 1'b0;
					end else if (adv) begin
						out_m.valid <= v_sx;
					end
				end
				always_ff @(posedge clk) begin
					if (adv) begin
						out_m.data.angle <= neg_sx ? AngleW'(-zr) : zr;
						out_m.data.end_of_vector <= last_sx;
					end
				end
			end
		end
	endgenerate
endmodule
`default_nettype wire

>>> rtl/core/atanp_checker.sv
// Checker: port-level assertions for the arc tangent block, with its bind.
`default_nettype none
`include "arctangent_polynomial_top_defines.svh"
module atanp_checker
	import atanp_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [AngleW-1:0] out_angle
);
	`AP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_angle), "output beat dropped under stall")
	`AP_ASSERT_NOW(a_ready_follows, clk, arst_n, !out_valid, in_ready, "input stalled while output empty")
	`AP_ASSERT_NOW(a_range, clk, arst_n, out_valid, $signed(out_angle) <= $signed(HalfPiQ29[AngleW-1:0]) && $signed(out_angle) >= -$signed(HalfPiQ29[AngleW-1:0]), "angle out of range")
endmodule
bind arctangent_polynomial_top atanp_checker u_atanp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_s.valid), .in_ready(in_s.ready),
	.out_valid(out_m.valid), .out_ready(out_m.ready), .out_angle(out_m.data.angle)
);
`default_nettype wire
